[sv/itoa_pkg.sv]
// Shared types, character codes and helpers for the integer to ASCII formatter.
package itoa_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned NDIG    = 10;          // decimal digits of a 32-bit magnitude
    localparam int unsigned CNT_W   = 4;           // holds 0..15

    localparam logic        MODE_DEC = 1'b0;
    localparam logic        MODE_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    // Powers of ten used by the restoring digit steps, index k is 10**k.
    localparam logic [VALUE_W-1:0] POW10 [NDIG] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // One digit job handed from the converter to the character emitter.
    typedef struct packed {
        logic                      neg;
        logic [CNT_W-1:0]          ndig;           // significant digits, 1..10
        logic [NDIG-1:0][3:0]      dig;            // dig[0] least significant
    } t_digits;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {3'd0, d};
        end else begin
            r = CH_LOWA + {3'd0, d - 4'd10};
        end
        return r;
    endfunction

endpackage

[sv/itoa_conv.sv]
// Pipelined magnitude to digit converter: one decimal digit per stage.
module itoa_conv (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [31:0]           i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output itoa_pkg::t_digits     o_digits
);
    localparam int unsigned NS = itoa_pkg::NDIG + 1;   // entry stage + one per digit

    logic                  r_vld  [NS];
    logic                  r_neg  [NS];
    logic                  r_hex  [NS];
    logic [31:0]           r_rem  [NS];
    logic [31:0]           r_raw  [NS];
    logic [itoa_pkg::NDIG-1:0][3:0] r_dig [NS];
    logic                  stall  [NS];

    // Stage i advances when downstream moves or it holds nothing.
    always_comb begin
        stall[NS-1] = r_vld[NS-1] && !i_ready;
        for (int i = NS-2; i >= 0; i--) begin
            stall[i] = r_vld[i] && stall[i+1];
        end
    end
    assign o_ready = !stall[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) r_vld[i] <= 1'b0;
        end else begin
            if (!stall[0]) r_vld[0] <= i_valid;
            for (int i = 1; i < NS; i++) begin
                if (!stall[i]) r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Entry stage: fold sign into magnitude (0 - word is correct for the most negative).
    always_ff @(posedge i_clk) begin
        if (!stall[0]) begin
            r_hex[0] <= i_mode;
            r_raw[0] <= i_value;
            r_neg[0] <= (i_mode == itoa_pkg::MODE_DEC) && i_value[31];
            r_rem[0] <= ((i_mode == itoa_pkg::MODE_DEC) && i_value[31]) ? (32'd0 - i_value)
                                                                         : i_value;
            r_dig[0] <= '0;
        end
    end

    // Digit stages: stage s yields decimal digit NDIG-s by repeated subtraction of 10**k
    // in a short binary search (8, 4, 2, 1 multiples).
    for (genvar s = 1; s < NS; s++) begin : g_dig
        localparam int unsigned K = itoa_pkg::NDIG - s;
        logic [34:0] p;
        logic [34:0] rem;
        logic [3:0]  d;
        logic [itoa_pkg::NDIG-1:0][3:0] n_dig;
        always_comb begin
            p   = {3'd0, itoa_pkg::POW10[K]};
            rem = {3'd0, r_rem[s-1]};
            d   = 4'd0;
            for (int b = 3; b >= 0; b--) begin
                if (rem >= (p << b)) begin
                    rem  = rem - (p << b);
                    d[b] = 1'b1;
                end
            end
            n_dig    = r_dig[s-1];
            n_dig[K] = d;
        end
        always_ff @(posedge i_clk) begin
            if (!stall[s]) begin
                r_hex[s] <= r_hex[s-1];
                r_raw[s] <= r_raw[s-1];
                r_neg[s] <= r_neg[s-1];
                r_rem[s] <= rem[31:0];
                r_dig[s] <= n_dig;
            end
        end
    end

    // Output: choose hex nibbles or decimal digits and count significant ones.
    always_comb begin
        o_valid         = r_vld[NS-1];
        o_digits.neg    = r_neg[NS-1];
        o_digits.ndig   = 4'd1;
        if (r_hex[NS-1]) begin
            for (int i = 0; i < itoa_pkg::NDIG; i++) begin
                o_digits.dig[i] = (i < 8) ? r_raw[NS-1][4*(i%8) +: 4] : 4'd0;
            end
        end else begin
            o_digits.dig = r_dig[NS-1];
        end
        for (int i = 1; i < itoa_pkg::NDIG; i++) begin
            if (o_digits.dig[i] != 4'd0) o_digits.ndig = itoa_pkg::CNT_W'(i + 1);
        end
    end

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digits))
        else $error("digit job changed under stall");
    a_ndig : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_digits.ndig >= 4'd1 && o_digits.ndig <= 4'd10)
        else $error("digit count out of range");
    a_hexneg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_digits.neg |-> !r_hex[NS-1])
        else $error("sign in hex mode");
endmodule

[sv/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: digit pipeline and character emitter.
//
//  channel  | dir | tdata bits                         | tuser      | tlast
//  s_axis   | in  | [31:0] value                       | [0] action |  -
//  m_axis   | out | [6:0] ascii_char, [7] zero pad     |  -         |  last
//
// A value runs through 11 register stages (sign fold, one stage per decimal digit)
// and then leaves one character per cycle while m_axis_tready is high: 1 to 11
// characters per value at the emitter, which sets the sustained rate. The first
// character comes from the emitter's job register, loaded from the last stage.
// Reset clears all valid bits; payload registers are not reset.
// Backpressure stalls each stage in place; nothing is dropped or repeated.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] ascii_char
    output logic        m_axis_tlast
);
    logic              cv_valid;
    logic              cv_ready;
    itoa_pkg::t_digits cv_dig;

    itoa_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_mode   (s_axis_tuser[0]),
        .i_value  (s_axis_tdata),
        .o_valid  (cv_valid),
        .i_ready  (cv_ready),
        .o_digits (cv_dig)
    );

    // Emitter: hold one digit job, walk characters out, then take the next job.
    logic                         r_busy, n_busy;
    itoa_pkg::t_digits            r_job;
    logic [itoa_pkg::CNT_W-1:0]   r_pos, n_pos;     // chars left after current
    logic                         r_sign, n_sign;   // minus still to send
    logic [itoa_pkg::CNT_W-1:0]   cur_idx;
    logic                         take;

    assign cur_idx       = r_pos;
    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {1'b0, r_sign ? itoa_pkg::CH_MINUS
                                         : itoa_pkg::digit_char(r_job.dig[cur_idx])};
    assign m_axis_tlast  = !r_sign && (r_pos == '0);

    // Take a new job when empty or when the final character transfers.
    assign take     = !r_busy || (m_axis_tready && m_axis_tlast);
    assign cv_ready = take;

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        n_sign = r_sign;
        if (take) begin
            n_busy = cv_valid;
            n_sign = cv_dig.neg;
            n_pos  = cv_dig.ndig - 4'd1;
        end else if (m_axis_tready) begin
            if (r_sign) begin
                n_sign = 1'b0;
            end else begin
                n_pos = r_pos - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_sign <= n_sign;
        if (take) r_job <= cv_dig;
    end

    a_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output changed under stall");
    a_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pos < 4'd10)
        else $error("digit index out of range");
    a_sign : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_sign && m_axis_tready |=> !r_sign && r_busy)
        else $error("minus not followed by digits");
endmodule
